// ----- hw/rtl/crpm_pkg.sv -----
`timescale 1ns / 1ps

package crpm_pkg;

	localparam int OFS_W = 13;
	localparam logic [OFS_W-1:0] MAX_BYTES = 13'd4096;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BADLEN  = 3'd1;
	localparam logic [2:0] ST_NOSPACE = 3'd2;
	localparam logic [2:0] ST_NODATA  = 3'd3;
	localparam logic [2:0] ST_WRAPPED = 3'd4;

	localparam logic CMD_WRITE   = 1'b0;
	localparam logic CMD_CONSUME = 1'b1;

	localparam logic REG_BUFFER_LENGTH = 1'b0;

	typedef struct packed {
		logic             command;
		logic [OFS_W-1:0] length;
	} cmd_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [11:0]      offset;
		logic [OFS_W-1:0] count;
		logic             now_empty;
		logic             now_full;
	} res_t;

endpackage

// ----- hw/rtl/contiguous_ring_pointer_manager.sv -----
`timescale 1ns / 1ps

// a command accepted with start is held in the input register (v_s1, cmd_s1); the
// pointer update then registers the result and strobes done
// throughput: one command per cycle, busy stays low; the pointer update is a single
// registered pass (a few subtract/compare on 13-bit offsets)
// reset: buffer_length returns to 4096, ring is empty, no result pending

module contiguous_ring_pointer_manager
	import crpm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        req,
	output logic        done,
	output res_t        result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic             v_s1;
	cmd_t             cmd_s1;
	logic [OFS_W-1:0] len_q;
	logic [OFS_W-1:0] wo_q;
	logic [OFS_W-1:0] ro_q;
	logic [OFS_W-1:0] wrap_q;
	logic             full_q;
	logic             empty_q;

	logic [OFS_W-1:0] wo_d;
	logic [OFS_W-1:0] ro_d;
	logic [OFS_W-1:0] wrap_d;
	logic             full_d;
	logic             empty_d;
	res_t             res_d;

	logic             cfg_wr;
	logic [OFS_W-1:0] cfg_len;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BUFFER_LENGTH);
	assign prdata = (paddr[2] == REG_BUFFER_LENGTH) ? {19'd0, len_q} : 32'd0;

	always_comb begin
		cfg_len = pwdata[OFS_W-1:0];
		if (cfg_len == '0) begin
			cfg_len = 13'd1;
		end else if (cfg_len > MAX_BYTES) begin
			cfg_len = MAX_BYTES;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_s1 <= req;
		end
	end

	// pointer update for the command in the input register
	always_comb begin
		logic [OFS_W-1:0] len;
		logic [OFS_W-1:0] room;
		logic [OFS_W-1:0] avail;
		logic             to_mark;
		len     = cmd_s1.length;
		wo_d    = wo_q;
		ro_d    = ro_q;
		wrap_d  = wrap_q;
		full_d  = full_q;
		empty_d = empty_q;
		room    = '0;
		avail   = '0;
		to_mark = 1'b0;
		res_d   = '0;
		res_d.status = ST_OK;

		if (len == '0) begin
			res_d.status = ST_BADLEN;
		end else if (cmd_s1.command == CMD_WRITE) begin
			if (wo_q == ro_q && !empty_q) begin
				res_d.status = ST_NOSPACE;
			end else if (wo_q >= ro_q) begin
				room = (len_q > wo_q) ? len_q - wo_q : '0;
				if (room >= len) begin
					res_d.offset = wo_q[11:0];
					res_d.count  = len;
					wo_d         = wo_q + len;
					wrap_d       = len_q;
					full_d       = 1'b0;
					empty_d      = 1'b0;
				end else if (ro_q < len) begin
					res_d.status = ST_NOSPACE;
				end else begin
					res_d.count = len;
					wrap_d      = wo_q;
					wo_d        = len;
					full_d      = (ro_q == len);
					empty_d     = 1'b0;
				end
			end else begin
				room = ro_q - wo_q;
				if (room < len) begin
					res_d.status = ST_NOSPACE;
				end else begin
					res_d.offset = wo_q[11:0];
					res_d.count  = len;
					wo_d         = wo_q + len;
					full_d       = (room == len);
					empty_d      = 1'b0;
				end
			end
		end else begin
			if (wo_q == ro_q) begin
				if (!full_q) begin
					empty_d      = 1'b1;
					res_d.status = ST_NODATA;
				end else begin
					to_mark = 1'b1;
				end
			end else if (wo_q > ro_q) begin
				avail        = wo_q - ro_q;
				res_d.offset = ro_q[11:0];
				res_d.count  = (avail > len) ? len : avail;
				ro_d         = ro_q + res_d.count;
				empty_d      = (res_d.count == avail);
				full_d       = 1'b0;
			end else begin
				to_mark = 1'b1;
			end

			if (to_mark) begin
				avail = (wrap_q > ro_q) ? wrap_q - ro_q : '0;
				if (avail == '0) begin
					ro_d         = '0;
					res_d.status = ST_WRAPPED;
				end else begin
					res_d.offset = ro_q[11:0];
					if (avail >= len) begin
						ro_d        = ro_q + len;
						res_d.count = len;
					end else begin
						ro_d        = '0;
						res_d.count = avail;
					end
					empty_d = 1'b0;
					full_d  = 1'b0;
				end
			end
		end
		res_d.now_empty = empty_d;
		res_d.now_full  = full_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= MAX_BYTES;
			wo_q    <= '0;
			ro_q    <= '0;
			wrap_q  <= MAX_BYTES;
			full_q  <= 1'b0;
			empty_q <= 1'b1;
			done    <= 1'b0;
		end else begin
			done <= v_s1;
			if (cfg_wr) begin
				len_q   <= cfg_len;
				wo_q    <= '0;
				ro_q    <= '0;
				wrap_q  <= cfg_len;
				full_q  <= 1'b0;
				empty_q <= 1'b1;
			end else if (v_s1) begin
				wo_q    <= wo_d;
				ro_q    <= ro_d;
				wrap_q  <= wrap_d;
				full_q  <= full_d;
				empty_q <= empty_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			result <= res_d;
		end
	end

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(full_q && empty_q))
		else $error("full and empty set together");

	a_wo_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wo_q <= len_q && wrap_q <= len_q)
		else $error("write offset or watermark beyond buffer end");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> result.count == '0 && result.offset == '0)
		else $error("failed command reports nonzero offset or count");

	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_OK |-> result.count != '0)
		else $error("successful transfer with zero count");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##1 done)
		else $error("accepted command produced no result");

endmodule
